FILE: rtl/trbs_pkg.sv
// Shared types, constants and split-table function for the tetrahedron split engine.
// Depends on nothing; used by every module in rtl.
`default_nettype none
package trbs_pkg;
    localparam int VERTEX_BITS = 24;
    localparam int OUT_VBITS = 24;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_ASSIGN = 2'd1;
    localparam logic [1:0] FUNC_EMIT   = 2'd2;

    localparam logic [3:0] OPT_NONE  = 4'd0;
    localparam logic [3:0] OPT_R1    = 4'd1;
    localparam logic [3:0] OPT_R1B1  = 4'd2;
    localparam logic [3:0] OPT_R1B2U = 4'd3;
    localparam logic [3:0] OPT_R1B2D = 4'd4;
    localparam logic [3:0] OPT_R2B2  = 4'd5;
    localparam logic [3:0] OPT_B1    = 4'd6;
    localparam logic [3:0] OPT_B2U   = 4'd7;
    localparam logic [3:0] OPT_B2D   = 4'd8;
    localparam logic [3:0] OPT_B4    = 4'd9;

    typedef logic [VERTEX_BITS-1:0] vid_t;

    // command handed from front to back: load or emit request with snapshot of state
    typedef struct packed {
        logic       emit;
        logic [3:0] option;
        logic [5:0] mask;
        vid_t [3:0] corner;
        vid_t [5:0] slot;
    } cmd_t;

    typedef struct packed {
        logic [3:0] option;
        logic [5:0] mask;
        vid_t [3:0] tet;
        logic       last;
    } res_t;

    function automatic logic [3:0] tet_count(input logic [3:0] opt);
        logic [3:0] n;
        case (opt)
            OPT_R1, OPT_B1:       n = 4'd2;
            OPT_R1B1:             n = 4'd3;
            OPT_R1B2U, OPT_R1B2D: n = 4'd6;
            OPT_R2B2, OPT_B4:     n = 4'd8;
            OPT_B2U, OPT_B2D:     n = 4'd4;
            default:              n = 4'd1;
        endcase
        return n;
    endfunction

    function automatic vid_t [3:0] q(input vid_t a, input vid_t b, input vid_t c, input vid_t d);
        vid_t [3:0] r;
        r[0] = a; r[1] = b; r[2] = c; r[3] = d;
        return r;
    endfunction

    function automatic vid_t [3:0] blue_cut(input logic [1:0] i, input vid_t [3:0] s,
                                            input vid_t v, input logic sel);
        vid_t [3:0] r;
        case (i)
            2'd0:    r = sel ? q(v, s[1], s[2], s[3]) : q(s[0], s[1], v, s[3]);
            2'd1:    r = sel ? q(v, s[1], s[2], s[3]) : q(s[0], s[1], s[2], v);
            2'd2:    r = sel ? q(s[0], s[1], v, s[3]) : q(s[0], v, s[2], s[3]);
            default: r = sel ? q(s[0], s[1], s[2], v) : q(s[0], v, s[2], s[3]);
        endcase
        return r;
    endfunction

    function automatic vid_t [3:0] red_cut(input logic i, input vid_t [3:0] s,
                                           input vid_t v, input logic sel);
        vid_t [3:0] r;
        if (!i)
            r = sel ? q(v, s[1], s[2], s[3]) : q(s[0], v, s[2], s[3]);
        else
            r = sel ? q(s[0], s[1], v, s[3]) : q(s[0], s[1], s[2], v);
        return r;
    endfunction

    // one sub-tetrahedron of the split under opt, picked by n
    function automatic vid_t [3:0] split_tet(input logic [3:0] opt, input logic [2:0] n,
                                             input logic [5:0] mk, input vid_t [3:0] cn,
                                             input vid_t [5:0] sl);
        vid_t a, b, c, d, r0, r1, b0, b1, b2, b3;
        vid_t [3:0] base, t, s;
        logic [1:0] k;
        logic r, src, lhs;
        a = cn[0]; b = cn[1]; c = cn[2]; d = cn[3];
        r0 = sl[0]; r1 = sl[1]; b0 = sl[2]; b1 = sl[3]; b2 = sl[4]; b3 = sl[5];
        base = q(a, b, c, d);
        k = (b0 != '0) ? 2'd0 : (b1 != '0) ? 2'd1 : (b2 != '0) ? 2'd2 : 2'd3;
        r = (r0 == '0);
        t = base;
        case (opt)
            OPT_R1: t = red_cut(r, base, r ? r1 : r0, n[0]);
            OPT_B1: t = blue_cut(k, base, sl[3'd2 + {1'b0, k}], n[0]);
            OPT_R1B1:
            begin
                if (!r) src = (k >= 2'd2);
                else src = !(k == 2'd0 || k == 2'd2);
                s = red_cut(r, base, r ? r1 : r0, src);
                if (n == 3'd2)
                    t = blue_cut(k, s, sl[3'd2 + {1'b0, k}], 1'b1);
                else if (n[0] == src)
                    t = blue_cut(k, s, sl[3'd2 + {1'b0, k}], 1'b0);
                else
                    t = red_cut(r, base, r ? r1 : r0, n[0]);
            end
            OPT_R1B2U:
            begin
                lhs = (b1 == '0);
                case (n)
                    3'd0: t = q(a, r0, (b0 != '0) ? b0 : c, r1);
                    3'd1: t = q(a, r0, r1, (b1 != '0) ? b1 : d);
                    3'd2: t = q(r0, b, (b2 != '0) ? b2 : c, r1);
                    3'd3: t = q(r0, b, r1, (b3 != '0) ? b3 : d);
                    3'd4: t = lhs ? q(r0, r1, b2, b0) : q(r0, r1, b1, b3);
                    default: t = lhs ? q(r1, c, b2, b0) : q(r1, d, b1, b3);
                endcase
            end
            OPT_R1B2D:
            begin
                lhs = (b2 == '0);
                case (n)
                    3'd0: t = q((b0 != '0) ? b0 : a, r0, c, r1);
                    3'd1: t = q((b1 != '0) ? b1 : a, r0, r1, d);
                    3'd2: t = q(r0, (b2 != '0) ? b2 : b, c, r1);
                    3'd3: t = q(r0, (b3 != '0) ? b3 : b, r1, d);
                    3'd4: t = lhs ? q(r0, r1, b0, b1) : q(r0, r1, b3, b2);
                    default: t = lhs ? q(a, r0, b0, b1) : q(r0, b, b2, b3);
                endcase
            end
            OPT_R2B2, OPT_B4:
            begin
                case (n)
                    3'd0: t = q(a, r0, b0, b1);
                    3'd1: t = q(r0, b, b2, b3);
                    3'd2: t = q(c, r1, b0, b2);
                    3'd3: t = q(d, r1, b3, b1);
                    3'd4: t = (opt == OPT_R2B2) ? q(r0, r1, b0, b1) : q(r0, b2, b0, b1);
                    3'd5: t = (opt == OPT_R2B2) ? q(r0, r1, b1, b3) : q(r0, b2, b1, b3);
                    3'd6: t = (opt == OPT_R2B2) ? q(r0, r1, b3, b2) : q(b2, r1, b0, b1);
                    default: t = (opt == OPT_R2B2) ? q(r0, r1, b2, b0) : q(b2, r1, b1, b3);
                endcase
            end
            OPT_B2U:
            begin
                case (n[1:0])
                    2'd0: t = mk[2] ? q(a, b, b0, b1) : q(a, b, b2, b3);
                    2'd1: t = mk[2] ? q(c, r1, b0, b) : q(c, r1, a, b2);
                    2'd2: t = mk[2] ? q(b0, b1, b, r1) : q(b2, b3, r1, a);
                    default: t = mk[2] ? q(d, r1, b, b1) : q(d, r1, b3, a);
                endcase
            end
            OPT_B2D:
            begin
                case (n[1:0])
                    2'd0: t = mk[2] ? q(a, r0, b0, d) : q(a, r0, c, b1);
                    2'd1: t = mk[2] ? q(b0, b2, c, d) : q(b1, b3, c, d);
                    2'd2: t = mk[2] ? q(b0, b2, d, r0) : q(b1, b3, r0, c);
                    default: t = mk[2] ? q(r0, b, b2, d) : q(r0, b, c, b3);
                endcase
            end
            default: t = base;
        endcase
        return t;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/trbs_front.sv
// Front end: accepts beats, keeps corner/edge state, classifies loads.
// Depends on trbs_pkg.
`default_nettype none
module trbs_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        func,
    input  wire trbs_pkg::vid_t [3:0] vert,
    input  wire logic [3:0][15:0]  dist_val,
    input  wire logic [2:0]        edge_index,
    input  wire trbs_pkg::vid_t    edge_vertex,
    output logic                   q_valid,
    input  wire logic              q_ready,
    output trbs_pkg::cmd_t         q_cmd
);
    trbs_pkg::vid_t [3:0] corner_reg;
    trbs_pkg::vid_t [5:0] slot_reg;
    logic [5:0] mark_reg;
    logic [3:0] opt_reg;
    logic       qv_reg;
    trbs_pkg::cmd_t qc_reg;

    logic [3:0] pos, neg;
    logic [5:0] m0, mf;
    logic [1:0] cr;
    logic [2:0] cb;
    logic [3:0] opt;
    logic       acc;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            neg[i] = dist_val[i][15];
            pos[i] = !dist_val[i][15] && (dist_val[i] != 16'd0);
        end
        m0[0] = (pos[0] && neg[1]) || (neg[0] && pos[1]);
        m0[1] = (pos[2] && neg[3]) || (neg[2] && pos[3]);
        m0[2] = (pos[0] && neg[2]) || (neg[0] && pos[2]);
        m0[3] = (pos[0] && neg[3]) || (neg[0] && pos[3]);
        m0[4] = (pos[1] && neg[2]) || (neg[1] && pos[2]);
        m0[5] = (pos[1] && neg[3]) || (neg[1] && pos[3]);
        cr = {1'b0, m0[0]} + {1'b0, m0[1]};
        cb = {2'b0, m0[2]} + {2'b0, m0[3]} + {2'b0, m0[4]} + {2'b0, m0[5]};
        opt = trbs_pkg::OPT_NONE;
        if (cr == 2'd0)
        begin
            if (cb == 3'd1) opt = trbs_pkg::OPT_B1;
            else if (cb == 3'd2)
                opt = ((m0[2] && m0[3]) || (m0[4] && m0[5])) ? trbs_pkg::OPT_B2U
                                                              : trbs_pkg::OPT_B2D;
            else if (cb == 3'd4) opt = trbs_pkg::OPT_B4;
        end
        else if (cr == 2'd1)
        begin
            if (cb == 3'd0) opt = trbs_pkg::OPT_R1;
            else if (cb == 3'd1) opt = trbs_pkg::OPT_R1B1;
            else if (cb == 3'd2) opt = m0[1] ? trbs_pkg::OPT_R1B2U : trbs_pkg::OPT_R1B2D;
        end
        else if (cb == 3'd2) opt = trbs_pkg::OPT_R2B2;
        mf = m0;
        case (opt)
            trbs_pkg::OPT_R1B2U, trbs_pkg::OPT_B2D: mf[0] = 1'b1;
            trbs_pkg::OPT_R1B2D, trbs_pkg::OPT_B2U: mf[1] = 1'b1;
            trbs_pkg::OPT_B4:   mf[1:0] = 2'b11;
            trbs_pkg::OPT_R2B2: mf[5:2] = 4'hf;
            default: ;
        endcase
    end

    assign in_ready = !qv_reg || q_ready;
    assign acc = in_valid && in_ready;
    assign q_valid = qv_reg;
    assign q_cmd = qc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg <= '0;
            slot_reg   <= '0;
            mark_reg   <= '0;
            opt_reg    <= trbs_pkg::OPT_NONE;
            qv_reg     <= 1'b0;
        end
        else
        begin
            if (q_ready) qv_reg <= 1'b0;
            if (acc)
            begin
                unique case (func)
                    trbs_pkg::FUNC_LOAD:
                    begin
                        corner_reg <= vert;
                        slot_reg   <= '0;
                        mark_reg   <= mf;
                        opt_reg    <= opt;
                        qv_reg     <= 1'b1;
                    end
                    trbs_pkg::FUNC_ASSIGN:
                    begin
                        if (edge_index < 3'd6)
                        begin
                            slot_reg[edge_index] <= edge_vertex;
                            mark_reg[edge_index] <= 1'b1;
                        end
                    end
                    trbs_pkg::FUNC_EMIT: qv_reg <= 1'b1;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            qc_reg.emit   <= (func == trbs_pkg::FUNC_EMIT);
            qc_reg.option <= (func == trbs_pkg::FUNC_LOAD) ? opt : opt_reg;
            qc_reg.mask   <= (func == trbs_pkg::FUNC_LOAD) ? mf : mark_reg;
            qc_reg.corner <= corner_reg;
            qc_reg.slot   <= slot_reg;
        end
    end

    a_emit_opt: assert property (@(posedge clk) disable iff (!rst_n)
        acc && func == trbs_pkg::FUNC_EMIT |=> q_valid && q_cmd.emit && q_cmd.option == opt_reg)
        else $error("emit command lost option");
    a_load_mask: assert property (@(posedge clk) disable iff (!rst_n)
        acc && func == trbs_pkg::FUNC_LOAD |=> mark_reg == q_cmd.mask && slot_reg == '0)
        else $error("load state mismatch");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && !q_ready |=> q_valid && $stable(q_cmd))
        else $error("queued command changed");
endmodule
`default_nettype wire

FILE: rtl/trbs_back.sv
// Back end: expands one command into result beats through an output register.
// Depends on trbs_pkg.
`default_nettype none
module trbs_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  wire trbs_pkg::cmd_t q_cmd,
    output logic                out_valid,
    input  wire logic           out_ready,
    output trbs_pkg::res_t      out_res
);
    logic [2:0] idx_reg;
    logic       ov_reg;
    trbs_pkg::res_t or_reg;
    logic [3:0] n;
    logic       adv, fin;
    trbs_pkg::vid_t [3:0] t;

    assign n = q_cmd.emit ? trbs_pkg::tet_count(q_cmd.option) : 4'd1;
    assign fin = ({1'b0, idx_reg} == n - 4'd1);
    assign adv = q_valid && (!ov_reg || out_ready);
    assign q_ready = adv && fin;
    assign out_valid = ov_reg;
    assign out_res = or_reg;
    assign t = q_cmd.emit ? trbs_pkg::split_tet(q_cmd.option, idx_reg, q_cmd.mask,
                                                q_cmd.corner, q_cmd.slot) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            if (out_ready) ov_reg <= 1'b0;
            if (adv)
            begin
                ov_reg  <= 1'b1;
                idx_reg <= fin ? 3'd0 : idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            or_reg.option <= q_cmd.option;
            or_reg.mask   <= q_cmd.mask;
            or_reg.tet    <= t;
            or_reg.last   <= fin;
        end
    end

    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        !q_cmd.emit && q_valid |-> idx_reg == 3'd0)
        else $error("load result index");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(idx_reg))
        else $error("index moved during stall");
    a_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> q_valid && fin)
        else $error("early pop");
endmodule
`default_nettype wire

FILE: rtl/tetra_red_blue_split_engine_top.sv
// Tetrahedron red/blue split engine: a load beat classifies one tetrahedron and
// yields one beat; an assign beat gives none; an emit beat yields 1 to 8 beats,
// one per cycle while m_tready does not stall, from the split-table unit, tlast
// on the final one. A one-entry command queue parts the front from the back: an
// accepted beat is registered in the queue entry, then in the back end's output
// register, before its first result is valid; the input then waits only while
// the queue entry, which an emit holds until its last result, is being expanded.
// Depends on trbs_pkg, trbs_front, trbs_back.
`default_nettype none
module tetra_red_blue_split_engine_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // func[1:0] vert_a..vert_d[97:2] dist_a..dist_d[161:98] edge_index[164:162]
    // edge_vertex[188:165], zero fill to 192
    input  wire logic [191:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // option[3:0] split_mask[9:4] tet_v0..tet_v3[105:10], zero fill to 112
    output logic [111:0]      m_tdata,
    output logic              m_tlast
);
    logic q_valid, q_ready;
    trbs_pkg::cmd_t q_cmd;
    trbs_pkg::res_t res;
    trbs_pkg::vid_t [3:0] vert;
    logic [3:0][15:0] dist_val;
    trbs_pkg::vid_t edge_vertex;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            vert[i] = trbs_pkg::VERTEX_BITS'(s_tdata[2 + 24*i +: 24]);
            dist_val[i] = s_tdata[98 + 16*i +: 16];
        end
        edge_vertex = trbs_pkg::VERTEX_BITS'(s_tdata[188:165]);
    end

    trbs_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .func(s_tdata[1:0]), .vert(vert), .dist_val(dist_val),
        .edge_index(s_tdata[164:162]),
        .edge_vertex(edge_vertex),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    trbs_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    always_comb
    begin
        m_tdata = '0;
        m_tdata[3:0] = res.option;
        m_tdata[9:4] = res.mask;
        for (int i = 0; i < 4; i++)
            m_tdata[10 + trbs_pkg::OUT_VBITS*i +: trbs_pkg::OUT_VBITS] =
                trbs_pkg::OUT_VBITS'(res.tet[i]);
        m_tlast = res.last;
    end
endmodule
`default_nettype wire
